// ===== hdl/tis_pkg.sv =====
// Shared types, constants and helper functions for the timed ignition sequencer.
// Used by the step logic, the seconds converter, the top level and the port checker.
// No dependencies.
package tis_pkg;

	// Item kinds carried on the request tuser.
	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_FIRE = 2'd1,
		KIND_SET  = 2'd2
	} kind_t;

	// Sequencer phase, held one-hot inside the block.
	typedef enum logic [5:0] {
		PH_UNINIT    = 6'b000001,
		PH_READY     = 6'b000010,
		PH_COUNTDOWN = 6'b000100,
		PH_FIRE      = 6'b001000,
		PH_FAILED    = 6'b010000,
		PH_COMPLETE  = 6'b100000
	} phase_t;

	// Phase codes as reported in seq_state and taken by set-state commands.
	localparam logic [2:0] SEQ_UNINIT    = 3'd0;
	localparam logic [2:0] SEQ_READY     = 3'd1;
	localparam logic [2:0] SEQ_COUNTDOWN = 3'd2;
	localparam logic [2:0] SEQ_FIRE      = 3'd3;
	localparam logic [2:0] SEQ_FAILED    = 3'd4;
	localparam logic [2:0] SEQ_COMPLETE  = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_LEAD_MS      = 3'd0;
	localparam logic [2:0] REG_CHAMBER_LIM  = 3'd1;
	localparam logic [2:0] REG_MAINLINE_MIN = 3'd2;
	localparam logic [2:0] REG_COLDFLOW     = 3'd3;
	localparam logic [2:0] REG_SKIP_LINE    = 3'd4;
	localparam logic [2:0] REG_DEFAULT_BURN = 3'd5;
	localparam logic [2:0] REG_MAX_BURN     = 3'd6;
	localparam int         CFG_DATA_W       = 16;

	// Abort codes.
	localparam logic [1:0] ABORT_PREFIRE = 2'd0;
	localparam logic [1:0] ABORT_ARM     = 2'd1;
	localparam logic [1:0] ABORT_CHAMBER = 2'd2;

	// Action codes.
	localparam logic [3:0] ACT_NONE      = 4'd0;
	localparam logic [3:0] ACT_CD_BASE   = 4'd1;
	localparam logic [3:0] ACT_POST_BASE = 4'd8;
	localparam logic [3:0] ACT_LAST_POST = 4'd14;

	// Event table positions with special handling.
	localparam logic [2:0] EV_PREFIRE = 3'd2;
	localparam logic [2:0] EV_ARM     = 3'd3;
	localparam logic [2:0] EV_LAST    = 3'd6;
	localparam logic [2:0] EV_NONE    = 3'd7;

	// Reset values of the configuration and state.
	localparam logic [15:0] RST_LEAD_MS      = 16'd20000;
	localparam logic [14:0] RST_CHAMBER_LIM  = 15'd500;
	localparam logic [14:0] RST_MAINLINE_MIN = 15'd300;
	localparam logic [3:0]  RST_DEFAULT_BURN = 4'd6;
	localparam logic [3:0]  RST_MAX_BURN     = 4'd10;
	localparam logic [13:0] RST_BURN_MS      = 14'd6000;

	// Seconds conversion: floor(a / 1000) = (a * SECS_RECIP) >> SECS_SHIFT for a < 2^17.
	localparam int          SECS_SHIFT  = 27;
	localparam logic [17:0] SECS_RECIP  = 18'd134218;
	localparam logic [31:0] SECS_SAT_MS = 32'd128000;

	typedef struct packed {
		logic [15:0] lead_ms;
		logic [14:0] chamber_limit;
		logic [14:0] mainline_min;
		logic        coldflow;
		logic        skip_line_check;
		logic [3:0]  default_burn;
		logic [3:0]  max_burn;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] start_time;
		logic [2:0]  event_index;
		logic [13:0] burn_ms;
	} state_t;

	// Request payload, first field in the highest bits.
	typedef struct packed {
		logic signed [15:0] chamber_pressure;
		logic signed [15:0] line_press;
		logic               arm_ok;
		logic               igniter_ok;
		logic               interlock_ok;
		logic [3:0]         valve_ok;
		logic [2:0]         cmd_phase;
		logic [3:0]         burn_seconds;
		logic [31:0]        now_ms;
	} item_t;

	// Result payload, first field in the highest bits.
	typedef struct packed {
		logic [2:0]        seq_state;
		logic              post_fire;
		logic [3:0]        burn_echo;
		logic              fire_accepted;
		logic [1:0]        abort_code;
		logic              abort_valid;
		logic signed [7:0] countdown_s;
		logic              report_valid;
		logic [3:0]        action;
	} res_t;

	localparam int ITEM_W      = $bits(item_t);
	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_UNINIT:    code = SEQ_UNINIT;
			PH_READY:     code = SEQ_READY;
			PH_COUNTDOWN: code = SEQ_COUNTDOWN;
			PH_FIRE:      code = SEQ_FIRE;
			PH_FAILED:    code = SEQ_FAILED;
			PH_COMPLETE:  code = SEQ_COMPLETE;
			default:      code = SEQ_FAILED;
		endcase
		return code;
	endfunction

	// Commandable phases only; anything above FAILED falls to FAILED.
	function automatic phase_t phase_from_code(input logic [2:0] code);
		phase_t ph;
		case (code)
			SEQ_UNINIT:    ph = PH_UNINIT;
			SEQ_READY:     ph = PH_READY;
			SEQ_COUNTDOWN: ph = PH_COUNTDOWN;
			SEQ_FIRE:      ph = PH_FIRE;
			default:       ph = PH_FAILED;
		endcase
		return ph;
	endfunction

	// Countdown event offsets in ms relative to T0.
	function automatic logic signed [31:0] cd_offset(input logic [2:0] idx);
		logic signed [31:0] ofs;
		case (idx)
			3'd0:    ofs = -32'sd10000;
			3'd1:    ofs = -32'sd9000;
			3'd2:    ofs = -32'sd6000;
			3'd3:    ofs = -32'sd5000;
			3'd4:    ofs = -32'sd3000;
			3'd5:    ofs = -32'sd2000;
			default: ofs = 32'sd0;
		endcase
		return ofs;
	endfunction

	// Post-burn event offsets in ms after the end of the burn.
	function automatic logic [14:0] post_offset(input logic [2:0] idx);
		logic [14:0] ofs;
		case (idx)
			3'd0:    ofs = 15'd0;
			3'd1:    ofs = 15'd1000;
			3'd2:    ofs = 15'd3000;
			3'd3:    ofs = 15'd5000;
			3'd4:    ofs = 15'd10000;
			3'd5:    ofs = 15'd12000;
			default: ofs = 15'd20000;
		endcase
		return ofs;
	endfunction

	// Burn length in ms; the constant multiply reduces to shifts and adds.
	function automatic logic [13:0] burn_ms_of(input logic [3:0] secs);
		return 14'(secs) * 14'd1000;
	endfunction

endpackage

// ===== hdl/tis_secs.sv =====
// Converts signed elapsed milliseconds to whole seconds, truncated toward zero
// and saturated to +-127, using a reciprocal multiply. Depends on tis_pkg.
module tis_secs
	import tis_pkg::*;
(
	input  logic signed [31:0] elapsed_ms,
	output logic signed [7:0]  secs
);

	logic        neg;
	logic [31:0] mag;
	logic        sat;
	logic [34:0] prod;
	logic [6:0]  quot;

	assign neg  = elapsed_ms[31];
	assign mag  = neg ? 32'(-elapsed_ms) : 32'(elapsed_ms);
	assign sat  = mag >= SECS_SAT_MS;
	// Below the saturation point the magnitude fits in 17 bits.
	assign prod = 35'(mag[16:0]) * 35'(SECS_RECIP);
	assign quot = sat ? 7'd127 : prod[SECS_SHIFT+6:SECS_SHIFT];
	assign secs = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

// ===== hdl/tis_step.sv =====
// Next-state and result logic for one sequencer request.
// Depends on tis_pkg and tis_secs.
module tis_step
	import tis_pkg::*;
(
	input  kind_t  kind,
	input  item_t  item,
	input  cfg_t   cfg,
	input  state_t cur,
	output state_t nxt,
	output res_t   res
);

	logic [31:0]        elapsed;
	logic signed [7:0]  secs;
	logic [3:0]         len;
	logic               idx_ok;
	logic               cd_hit;
	logic [16:0]        post_due;
	logic               post_hit;
	logic               in_burn;
	logic               over_limit;
	logic               low_mainline;
	logic               prefire_good;

	assign elapsed = item.now_ms - cur.start_time - {16'd0, cfg.lead_ms};

	tis_secs u_secs (
		.elapsed_ms (elapsed),
		.secs       (secs)
	);

	assign len      = (item.burn_seconds == 4'd0) ? cfg.default_burn : item.burn_seconds;
	assign idx_ok   = cur.event_index != EV_NONE;
	assign cd_hit   = $signed(elapsed) >= cd_offset(cur.event_index);
	assign post_due = 17'(post_offset(cur.event_index)) + 17'(cur.burn_ms);
	assign post_hit = $signed({elapsed[31], elapsed}) >= $signed({16'd0, post_due});
	assign in_burn  = $signed(elapsed) <= $signed({18'd0, cur.burn_ms});

	assign over_limit   = $signed({item.chamber_pressure[15], item.chamber_pressure})
		> $signed({2'b00, cfg.chamber_limit});
	assign low_mainline = $signed({item.line_press[15], item.line_press})
		< $signed({2'b00, cfg.mainline_min});
	assign prefire_good = (item.valve_ok == 4'hF) && item.interlock_ok
		&& (cfg.coldflow || item.igniter_ok) && (cfg.skip_line_check || !low_mainline);

	always_comb begin
		nxt = cur;
		res = '0;
		case (kind)
			KIND_SET: begin
				nxt.phase       = phase_from_code(item.cmd_phase);
				nxt.event_index = 3'd0;
				if (nxt.phase == PH_COUNTDOWN) begin
					nxt.start_time = item.now_ms;
				end
			end
			KIND_FIRE: begin
				if (cur.phase == PH_READY && len <= cfg.max_burn) begin
					nxt.phase         = PH_COUNTDOWN;
					nxt.event_index   = 3'd0;
					nxt.start_time    = item.now_ms;
					nxt.burn_ms       = burn_ms_of(len);
					res.fire_accepted = 1'b1;
					res.burn_echo     = len;
				end
			end
			KIND_TICK: begin
				case (cur.phase)
					PH_COUNTDOWN: begin
						res.report_valid = 1'b1;
						res.countdown_s  = secs;
						if (idx_ok && cd_hit) begin
							res.action      = ACT_CD_BASE + {1'b0, cur.event_index};
							nxt.event_index = cur.event_index + 3'd1;
							if (cur.event_index == EV_PREFIRE) begin
								if (!prefire_good) begin
									res.abort_valid = 1'b1;
									res.abort_code  = ABORT_PREFIRE;
								end
							end else if (cur.event_index == EV_ARM) begin
								if (!item.arm_ok) begin
									res.abort_valid = 1'b1;
									res.abort_code  = ABORT_ARM;
								end
							end else if (cur.event_index == EV_LAST) begin
								nxt.phase       = PH_FIRE;
								nxt.event_index = 3'd0;
							end
						end
					end
					PH_FIRE: begin
						res.report_valid = 1'b1;
						res.countdown_s  = secs;
						if (in_burn && over_limit) begin
							res.abort_valid = 1'b1;
							res.abort_code  = ABORT_CHAMBER;
						end
						if (idx_ok && post_hit) begin
							res.action      = ACT_POST_BASE + {1'b0, cur.event_index};
							nxt.event_index = cur.event_index + 3'd1;
							if (cur.event_index == EV_LAST) begin
								nxt.phase       = PH_COMPLETE;
								nxt.event_index = 3'd0;
								res.post_fire   = 1'b1;
							end
						end
					end
					PH_UNINIT, PH_READY, PH_FAILED, PH_COMPLETE: begin
					end
					default: begin
						nxt.phase = PH_FAILED;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.seq_state = phase_code(nxt.phase);
	end

endmodule

// ===== hdl/timed_ignition_sequencer_core.sv =====
// Top level of the timed ignition sequencer: request and result stream ports,
// configuration write port, input stage, sequencer state and result register.
// Depends on tis_pkg and tis_step.
//
// Use of the block:
// Requests arrive on the s_ stream. tuser carries the request kind (time tick,
// fire request or set-state command) and tdata the request fields. Every request
// gives exactly one result on the m_ stream: the action code of the event that
// fired, the countdown report, any abort, the fire acceptance and the phase
// after the request.
// An accepted request waits in the input register; then the step logic updates the
// sequencer state and loads the result register in the same cycle.
// Throughput is one request per cycle while the receiver does not stall. The state
// update for a request is registered with its result, so the next request sees it
// straight away; the critical path is the elapsed-time subtract followed by the
// seconds multiply.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more request; s_tready falls only when
// both are full.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and should only change while no request is in flight.
// Reset (arst_n low) empties both registers, returns the sequencer to the
// uninitialised phase and loads the default configuration.
module timed_ignition_sequencer_core
	import tis_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Requests
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// now_ms[31:0], burn_seconds[35:32], cmd_phase[38:36], valve_ok[42:39],
	// interlock_ok[43], igniter_ok[44], arm_ok[45], line_press[61:46],
	// chamber_pressure[77:62], zero fill[79:78]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]             s_tuser,
	// Results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// action[3:0], report_valid[4], countdown_s[12:5], abort_valid[13],
	// abort_code[15:14], fire_accepted[16], burn_echo[20:17], post_fire[21],
	// seq_state[24:22], zero fill[31:25]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int OUT_PAD = OUT_TDATA_W - RES_W;

	logic   valid_s1;
	item_t  item_s1;
	kind_t  kind_s1;
	logic   out_valid_q;
	res_t   out_q;
	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	res_t   res_nxt;
	logic   advance;

	// A request leaves the input register when the result register is free or
	// is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
			kind_s1 <= kind_t'(s_tuser);
		end
	end

	tis_step u_step (
		.kind (kind_s1),
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state moves on once per request, as it passes to the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_UNINIT;
			state_q.start_time  <= 32'd0;
			state_q.event_index <= 3'd0;
			state_q.burn_ms     <= RST_BURN_MS;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_nxt;
		end
	end

	// Configuration registers; writes to an unused index are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_ms         <= RST_LEAD_MS;
			cfg_q.chamber_limit   <= RST_CHAMBER_LIM;
			cfg_q.mainline_min    <= RST_MAINLINE_MIN;
			cfg_q.coldflow        <= 1'b0;
			cfg_q.skip_line_check <= 1'b0;
			cfg_q.default_burn    <= RST_DEFAULT_BURN;
			cfg_q.max_burn        <= RST_MAX_BURN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEAD_MS:      cfg_q.lead_ms         <= cfg_wdata;
				REG_CHAMBER_LIM:  cfg_q.chamber_limit   <= cfg_wdata[14:0];
				REG_MAINLINE_MIN: cfg_q.mainline_min    <= cfg_wdata[14:0];
				REG_COLDFLOW:     cfg_q.coldflow        <= cfg_wdata[0];
				REG_SKIP_LINE:    cfg_q.skip_line_check <= cfg_wdata[0];
				REG_DEFAULT_BURN: cfg_q.default_burn    <= cfg_wdata[3:0];
				REG_MAX_BURN:     cfg_q.max_burn        <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/tis_checker.sv =====
// Port checker for the timed ignition sequencer, bound to the top level.
// Depends on tis_pkg and timed_ignition_sequencer_core.
module tis_checker
	import tis_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	res_t res;

	assign res = res_t'(m_tdata[RES_W-1:0]);

	// A stalled result must stay put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Completion only comes with the last post-burn event.
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.post_fire |-> res.action == ACT_LAST_POST
			&& res.seq_state == SEQ_COMPLETE)
		else $error("post_fire without last post-burn event");

	// Aborts are raised only by ticks that also report the countdown.
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.abort_valid |-> res.report_valid)
		else $error("abort outside a countdown report");

	// An accepted fire request starts the countdown and fires nothing itself.
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.fire_accepted |-> res.seq_state == SEQ_COUNTDOWN
			&& res.action == ACT_NONE && res.burn_echo != 4'd0)
		else $error("inconsistent fire acceptance");

endmodule

bind timed_ignition_sequencer_core tis_checker u_tis_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for timed_ignition_sequencer_core: a directed table, then random
// countdown sequences under several settings, results checked by a predictor or a table.
// Depends on tis_pkg and timed_ignition_sequencer_core.
`timescale 1ns / 100ps

module tb;
	import tis_pkg::*;

	// The kind field is two bits wide, so the one code the block does not define gets a name.
	localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
	// Fire request time of the directed countdown; chosen so that the countdown wraps 2^32.
	localparam logic [31:0] T_REQ        = 32'hFFFF_F000;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          PHASES        = 7;
	localparam int          PHASE_ITEMS   = 200;

	typedef struct {
		logic [1:0] kind;
		item_t      item;
		bit         typed;
		res_t       want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [2:0]             cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Predictor copy of the configuration registers.
	logic [15:0] cf_lead;
	logic [14:0] cf_chamber;
	logic [14:0] cf_mainline;
	logic        cf_coldflow;
	logic        cf_test;
	logic [3:0]  cf_default;
	logic [3:0]  cf_max;

	// Predictor copy of the sequencer state; the phase is held as its reported code.
	logic [2:0]  pr_phase;
	logic [31:0] pr_start;
	logic [2:0]  pr_index;
	logic [13:0] pr_burn_ms;

	res_t        pending_results[$];
	stim_row_t   directed_rows[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          requests_sent = 0;
	int          burst_left = 0;
	logic [31:0] sim_ms;
	int          stall_tick = 0;
	int          stall_mode = 0;
	logic [15:0] stall_mask = '1;

	timed_ignition_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block stops answering.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Countdown event times in ms relative to T0, in firing order.
	function automatic int cd_event_ms(input logic [2:0] idx);
		case (idx)
			3'd0:    return -10000;
			3'd1:    return -9000;
			3'd2:    return -6000;
			3'd3:    return -5000;
			3'd4:    return -3000;
			3'd5:    return -2000;
			default: return 0;
		endcase
	endfunction

	// Post-burn event times in ms after the end of the burn.
	function automatic int post_event_ms(input logic [2:0] idx);
		case (idx)
			3'd0:    return 0;
			3'd1:    return 1000;
			3'd2:    return 3000;
			3'd3:    return 5000;
			3'd4:    return 10000;
			3'd5:    return 12000;
			default: return 20000;
		endcase
	endfunction

	task automatic reset_predictor();
		cf_lead     = 16'd20000;
		cf_chamber  = 15'd500;
		cf_mainline = 15'd300;
		cf_coldflow = 1'b0;
		cf_test     = 1'b0;
		cf_default  = 4'd6;
		cf_max      = 4'd10;
		pr_phase    = SEQ_UNINIT;
		pr_start    = '0;
		pr_index    = '0;
		pr_burn_ms  = 14'd6000;
	endtask

	// Applies one request to the predicted state and returns the result it should give.
	function automatic res_t advance_sequencer(input logic [1:0] kind, input item_t it);
		res_t        r;
		logic [3:0]  len;
		logic [31:0] diff;
		longint      t;
		longint      secs;
		logic        good;
		r = '0;
		case (kind)
			KIND_SET: begin
				pr_phase = (it.cmd_phase > SEQ_FAILED) ? SEQ_FAILED : it.cmd_phase;
				pr_index = '0;
				if (pr_phase == SEQ_COUNTDOWN)
					pr_start = it.now_ms;
			end
			KIND_FIRE: begin
				len = (it.burn_seconds == 4'd0) ? cf_default : it.burn_seconds;
				if (pr_phase == SEQ_READY && len <= cf_max) begin
					pr_phase        = SEQ_COUNTDOWN;
					pr_index        = '0;
					pr_start        = it.now_ms;
					pr_burn_ms      = 14'(len) * 14'd1000;
					r.fire_accepted = 1'b1;
					r.burn_echo     = len;
				end
			end
			KIND_TICK: begin
				if (pr_phase == SEQ_COUNTDOWN || pr_phase == SEQ_FIRE) begin
					// Time relative to T0, taken modulo 2^32 and read as signed.
					diff = it.now_ms - pr_start - 32'(cf_lead);
					t    = longint'($signed(diff));
					secs = t / 1000;
					if (secs > 127)
						secs = 127;
					else if (secs < -127)
						secs = -127;
					r.report_valid = 1'b1;
					r.countdown_s  = 8'(secs);
					if (pr_phase == SEQ_COUNTDOWN) begin
						if (pr_index < EV_NONE && t >= longint'(cd_event_ms(pr_index))) begin
							r.action = ACT_CD_BASE + 4'(pr_index);
							if (pr_index == EV_PREFIRE) begin
								good = it.valve_ok == 4'hF && it.interlock_ok
									&& (cf_coldflow || it.igniter_ok)
									&& (cf_test || longint'(it.line_press)
										>= longint'(cf_mainline));
								if (!good) begin
									r.abort_valid = 1'b1;
									r.abort_code  = ABORT_PREFIRE;
								end
							end else if (pr_index == EV_ARM && !it.arm_ok) begin
								r.abort_valid = 1'b1;
								r.abort_code  = ABORT_ARM;
							end
							if (pr_index == EV_LAST) begin
								pr_phase = SEQ_FIRE;
								pr_index = '0;
							end else begin
								pr_index = pr_index + 3'd1;
							end
						end
					end else begin
						if (t <= longint'(pr_burn_ms)
							&& longint'(it.chamber_pressure) > longint'(cf_chamber)) begin
							r.abort_valid = 1'b1;
							r.abort_code  = ABORT_CHAMBER;
						end
						if (pr_index < EV_NONE && t >= longint'(post_event_ms(pr_index))
							+ longint'(pr_burn_ms)) begin
							r.action = ACT_POST_BASE + 4'(pr_index);
							if (pr_index == EV_LAST) begin
								pr_phase    = SEQ_COMPLETE;
								pr_index    = '0;
								r.post_fire = 1'b1;
							end else begin
								pr_index = pr_index + 3'd1;
							end
						end
					end
				end else if (pr_phase > SEQ_COMPLETE) begin
					pr_phase = SEQ_FAILED;
				end
			end
			default: ;
		endcase
		r.seq_state = pr_phase;
		return r;
	endfunction

	// Absolute time at which the next pending event falls due.
	function automatic logic [31:0] next_event_due();
		int ofs;
		if (pr_phase == SEQ_FIRE)
			ofs = post_event_ms(pr_index) + int'(pr_burn_ms);
		else
			ofs = cd_event_ms(pr_index);
		return pr_start + 32'(cf_lead) + 32'(ofs);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic compare_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result %h with no request outstanding", got));
			return;
		end
		want = pending_results.pop_front();
		compare_field("action", got.action, want.action);
		compare_field("report_valid", got.report_valid, want.report_valid);
		compare_field("countdown_s", longint'(got.countdown_s), longint'(want.countdown_s));
		compare_field("abort_valid", got.abort_valid, want.abort_valid);
		compare_field("abort_code", got.abort_code, want.abort_code);
		compare_field("fire_accepted", got.fire_accepted, want.fire_accepted);
		compare_field("burn_echo", got.burn_echo, want.burn_echo);
		compare_field("post_fire", got.post_fire, want.post_fire);
		compare_field("seq_state", got.seq_state, want.seq_state);
	endtask

	// Result side: check every accepted result, and stall on a pattern drawn at the start of
	// each period from always ready, a repeating random mask and a fixed long stall.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(res_t'(m_tdata[RES_W-1:0]));
		if (stall_tick == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_mask = 16'($urandom());
		end
		stall_tick = (stall_tick + 1) % 64;
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= stall_mask[stall_tick % 16];
			default: m_tready <= (stall_tick % 32) >= 10;
		endcase
	end

	// Sends one request, in bursts of random length separated by random gaps, and records
	// the expected result once the request has been accepted.
	task automatic push_request(input logic [1:0] kind, input item_t it, input bit typed,
		input res_t want);
		int   gap;
		res_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_TDATA_W'(it);
		do
			@(posedge clk);
		while (!s_tready);
		predicted = advance_sequencer(kind, it);
		pending_results.push_back(typed ? want : predicted);
		requests_sent++;
	endtask

	// Lets every outstanding result arrive, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_LEAD_MS:      cf_lead     = value;
			REG_CHAMBER_LIM:  cf_chamber  = value[14:0];
			REG_MAINLINE_MIN: cf_mainline = value[14:0];
			REG_COLDFLOW:     cf_coldflow = value[0];
			REG_SKIP_LINE:    cf_test     = value[0];
			REG_DEFAULT_BURN: cf_default  = value[3:0];
			REG_MAX_BURN:     cf_max      = value[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int lead, input int chamber, input int mainline,
		input int coldflow, input int testm, input int dflt, input int maxb);
		write_register(REG_LEAD_MS, 16'(lead));
		write_register(REG_CHAMBER_LIM, 16'(chamber));
		write_register(REG_MAINLINE_MIN, 16'(mainline));
		write_register(REG_COLDFLOW, 16'(coldflow));
		write_register(REG_SKIP_LINE, 16'(testm));
		write_register(REG_DEFAULT_BURN, 16'(dflt));
		write_register(REG_MAX_BURN, 16'(maxb));
		cfg_we <= 1'b0;
	endtask

	task automatic add_row(input logic [1:0] k, input logic [31:0] now, input logic [3:0] burn,
		input logic [2:0] ns, input logic [3:0] valves, input logic [2:0] flags,
		input logic [15:0] mainline, input logic [15:0] chamber, input bit typed,
		input res_t want);
		stim_row_t r;
		r.kind                   = k;
		r.item.now_ms            = now;
		r.item.burn_seconds      = burn;
		r.item.cmd_phase         = ns;
		r.item.valve_ok          = valves;
		{r.item.arm_ok, r.item.igniter_ok, r.item.interlock_ok} = flags;
		r.item.line_press        = mainline;
		r.item.chamber_pressure  = chamber;
		r.typed                  = typed;
		r.want                   = want;
		directed_rows.push_back(r);
	endtask

	// Result with nothing reported but the phase and, possibly, a fire acceptance.
	function automatic res_t typed_result(input logic [2:0] seq, input logic acc,
		input logic [3:0] echo);
		res_t r;
		r               = '0;
		r.seq_state     = seq;
		r.fire_accepted = acc;
		r.burn_echo     = echo;
		return r;
	endfunction

	// Random request whose status fields mostly pass the pre-fire checks and whose pressures
	// cluster round the configured limits.
	function automatic item_t status_item(input logic [31:0] now);
		item_t       it;
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		it  = raw[ITEM_W-1:0];
		it.now_ms = now;
		if ($urandom_range(0, 9) != 0)
			it.valve_ok = 4'hF;
		if ($urandom_range(0, 9) != 0)
			it.interlock_ok = 1'b1;
		if ($urandom_range(0, 9) != 0)
			it.igniter_ok = 1'b1;
		if ($urandom_range(0, 9) != 0)
			it.arm_ok = 1'b1;
		case ($urandom_range(0, 5))
			0:       ;
			1:       it.line_press = {1'b0, cf_mainline} - 16'd1;
			2:       it.line_press = {1'b0, cf_mainline};
			default: it.line_press = 16'($urandom_range(cf_mainline, 32767));
		endcase
		case ($urandom_range(0, 5))
			0:       ;
			1:       it.chamber_pressure = {1'b0, cf_chamber};
			2:       it.chamber_pressure = {1'b0, cf_chamber} + 16'd1;
			default: it.chamber_pressure = 16'($urandom_range(0, cf_chamber));
		endcase
		return it;
	endfunction

	// One countdown from READY (or a direct jump into COUNTDOWN) run to its end, with ticks
	// that often land exactly on, or one ms short of, the next event time.
	task automatic run_countdown();
		item_t       it;
		logic [31:0] due;
		int          diff;
		int          span;
		int          roll;
		int          guard;
		sim_ms = $urandom();
		it = status_item(sim_ms);
		if ($urandom_range(0, 6) == 0) begin
			it.cmd_phase = SEQ_COUNTDOWN;
			push_request(KIND_SET, it, 1'b0, '0);
		end else begin
			it.cmd_phase = SEQ_READY;
			push_request(KIND_SET, it, 1'b0, '0);
			it = status_item(sim_ms);
			case ($urandom_range(0, 3))
				0:       it.burn_seconds = 4'd0;
				1:       it.burn_seconds = 4'($urandom_range(0, 15));
				default: it.burn_seconds = 4'($urandom_range(1, cf_max));
			endcase
			push_request(KIND_FIRE, it, 1'b0, '0);
		end
		guard = 0;
		while ((pr_phase == SEQ_COUNTDOWN || pr_phase == SEQ_FIRE) && guard < 250) begin
			guard++;
			due  = next_event_due();
			diff = $signed(due - sim_ms);
			span = int'(cf_lead) + int'(pr_burn_ms) + 20000;
			roll = $urandom_range(0, 99);
			if (roll < 30 && diff >= 0)
				sim_ms = due;
			else if (roll < 38 && diff > 0)
				sim_ms = due - 32'd1;
			else
				sim_ms = sim_ms + 32'($urandom_range(0, span / 25 + 1));
			it   = status_item(sim_ms);
			roll = $urandom_range(0, 99);
			if (roll < 95) begin
				push_request(KIND_TICK, it, 1'b0, '0);
			end else if (roll < 98) begin
				// A second fire request while counting down must be refused.
				push_request(KIND_FIRE, it, 1'b0, '0);
			end else begin
				push_request(2'($urandom_range(0, 3)), it, 1'b0, '0);
			end
		end
		if ($urandom_range(0, 1) == 0)
			push_request(KIND_TICK, status_item(sim_ms + 32'd1000), 1'b0, '0);
	endtask

	task automatic run_random(input int target);
		int          first;
		item_t       it;
		logic [95:0] raw;
		first = requests_sent;
		while (requests_sent - first < target) begin
			if ($urandom_range(0, 99) < 80) begin
				run_countdown();
			end else begin
				// Free-form request: any kind, any field value.
				raw = {$urandom(), $urandom(), $urandom()};
				it  = raw[ITEM_W-1:0];
				push_request(2'($urandom_range(0, 3)), it, 1'b0, '0);
			end
		end
	endtask

	initial begin
		reset_predictor();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset configuration: idle phases, the unknown kind,
		// uncommandable phases, refused fire requests, then one full countdown across the
		// 2^32 wrap with every abort, and the saturation of the seconds report.
		add_row(KIND_TICK, 32'd0, 4'd0, 3'd0, 4'h0, 3'b000, 16'h0000, 16'h0000, 1'b1,
			typed_result(SEQ_UNINIT, 1'b0, 4'd0));
		add_row(KIND_UNKNOWN, 32'hFFFF_FFFF, 4'd15, 3'd7, 4'hF, 3'b111, 16'h7FFF, 16'hFFFF,
			1'b1, typed_result(SEQ_UNINIT, 1'b0, 4'd0));
		add_row(KIND_FIRE, 32'd0, 4'd5, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_UNINIT, 1'b0, 4'd0));
		add_row(KIND_SET, 32'd0, 4'd0, 3'd7, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_FAILED, 1'b0, 4'd0));
		add_row(KIND_SET, 32'd0, 4'd0, 3'd5, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_FAILED, 1'b0, 4'd0));
		add_row(KIND_SET, 32'd0, 4'd0, SEQ_READY, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_READY, 1'b0, 4'd0));
		// Longer than the maximum burn, so refused.
		add_row(KIND_FIRE, 32'd0, 4'd11, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_READY, 1'b0, 4'd0));
		// Zero burn takes the default length.
		add_row(KIND_FIRE, T_REQ, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b1,
			typed_result(SEQ_COUNTDOWN, 1'b1, RST_DEFAULT_BURN));
		add_row(KIND_TICK, T_REQ + 32'd9999, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd10000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd11000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		// Pre-fire check fails on the valves and the mainline pressure.
		add_row(KIND_TICK, T_REQ + 32'd14000, 4'd0, 3'd0, 4'h7, 3'b111, 16'h8000, 16'h0000,
			1'b0, '0);
		// Arm failed.
		add_row(KIND_TICK, T_REQ + 32'd15000, 4'd0, 3'd0, 4'hF, 3'b011, 16'd300, 16'h0000,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd17000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd18000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd20000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000,
			1'b0, '0);
		// Chamber overpressure during the burn, then together with the first post-burn
		// event at the very end of the burn, then too late to count.
		add_row(KIND_TICK, T_REQ + 32'd20500, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h7FFF,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd26000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'd501,
			1'b0, '0);
		add_row(KIND_TICK, T_REQ + 32'd27000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h7FFF,
			1'b0, '0);
		// Well past every event: only one event may fire per tick.
		repeat (5)
			add_row(KIND_TICK, T_REQ + 32'd46000, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300,
				16'h0000, 1'b0, '0);
		add_row(KIND_SET, 32'd0, 4'd0, SEQ_COUNTDOWN, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b0,
			'0);
		add_row(KIND_TICK, 32'h7FFF_FFFF, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b0,
			'0);
		add_row(KIND_SET, 32'd0, 4'd0, SEQ_FIRE, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b0, '0);
		add_row(KIND_TICK, 32'h8000_4E20, 4'd0, 3'd0, 4'hF, 3'b111, 16'd300, 16'h8000, 1'b0,
			'0);
		add_row(KIND_SET, 32'd0, 4'd0, SEQ_UNINIT, 4'hF, 3'b111, 16'd300, 16'h0000, 1'b0, '0);
		foreach (directed_rows[i])
			push_request(directed_rows[i].kind, directed_rows[i].item, directed_rows[i].typed,
				directed_rows[i].want);

		// Random part: the reset settings first, then both extremes, then random settings.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1) begin
				drain();
				apply_settings(0, 0, 0, 1, 1, 1, 1);
			end else if (p == 2) begin
				drain();
				apply_settings(65535, 32767, 32767, 0, 0, 15, 15);
			end else if (p > 2) begin
				drain();
				apply_settings($urandom_range(0, 25000), $urandom_range(0, 2000),
					$urandom_range(0, 1000), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(1, 15), $urandom_range(1, 15));
			end
			run_random(PHASE_ITEMS);
		end

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
